FILE: rtl/kcl_pkg.sv
// Shared types and constants of the keypad code lock controller.
package kcl_pkg;

   localparam logic [3:0] KEY_A    = 4'd10;
   localparam logic [3:0] KEY_STAR = 4'd14;
   localparam logic [3:0] KEY_HASH = 4'd15;

   // Stored code after reset, first key first.
   localparam logic [0:3][3:0] RESET_CODE = {4'd6, 4'd6, 4'd0, 4'd1};

   // Saturation value of the key counter.
   localparam logic [4:0] COUNT_MAX = 5'd31;

   localparam logic [2:0] EV_NONE     = 3'd0;
   localparam logic [2:0] EV_STARTED  = 3'd1;
   localparam logic [2:0] EV_ECHO     = 3'd2;
   localparam logic [2:0] EV_UNLOCK   = 3'd3;
   localparam logic [2:0] EV_WRONG    = 3'd4;
   localparam logic [2:0] EV_CHANGED  = 3'd5;
   localparam logic [2:0] EV_MISMATCH = 3'd6;
   localparam logic [2:0] EV_NEW_OK   = 3'd7;

   // One registered input event.
   typedef struct packed {
      logic       mode;
      logic [3:0] key_code;
   } item_type;

   // One result, as it leaves the engine for the output register.
   typedef struct packed {
      logic [2:0]  event_res;
      logic        unlock;
      logic        save_code;
      logic [15:0] code_word;
      logic [2:0]  phase;
      logic [4:0]  entered_count;
   } result_type;

endpackage

FILE: rtl/kcl_in_stage.sv
// Input register of the keypad code lock controller.
module kcl_in_stage
   import kcl_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  logic     req_mode,
   input  logic [3:0] req_key_code,
   input  logic     take,
   output logic     item_valid,
   output item_type item
);

   logic     valid_ff;
   item_type item_ff;

   // The register frees up in the same cycle that its beat moves on.
   assign req_stall  = valid_ff && !take;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff.mode     <= req_mode;
         item_ff.key_code <= req_key_code;
      end
   end

endmodule

FILE: rtl/kcl_engine.sv
// Lock state and the single-pass next-state and result logic.
module kcl_engine
   import kcl_pkg::*;
#(
   parameter int CODE_LEN = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  item_type   item,
   output result_type result
);

   localparam int IDX_W = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;
   localparam int SHOWN = (CODE_LEN < 4) ? CODE_LEN : 4;
   localparam logic [4:0] LEN = 5'(CODE_LEN);

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_OPEN    = 3'd1,
      PH_OLD     = 3'd2,
      PH_NEW     = 3'd3,
      PH_CONFIRM = 3'd4
   } phase_type;

   phase_type                    phase_ff, phase_in;
   logic                         match_ff, match_in;
   logic [4:0]                   count_ff, count_in;
   logic [CODE_LEN-1:0][3:0]     stored_ff, stored_in;
   logic [CODE_LEN-1:0][3:0]     first_ff, first_in;
   logic [CODE_LEN-1:0][3:0]     second_ff, second_in;
   logic [IDX_W-1:0]             idx;
   logic                         room;
   logic                         correct;
   logic [15:0]                  word;

   assign idx     = count_ff[IDX_W-1:0];
   assign room    = count_ff < LEN;
   assign correct = match_ff && (count_ff == LEN);

   always_comb begin
      phase_in  = phase_ff;
      match_in  = match_ff;
      count_in  = count_ff;
      stored_in = stored_ff;
      first_in  = first_ff;
      second_in = second_ff;
      result.event_res = EV_NONE;
      result.unlock    = 1'b0;
      result.save_code = 1'b0;

      case (phase_ff)
         PH_OPEN, PH_OLD, PH_NEW, PH_CONFIRM: begin
            if (item.mode) begin
               // The button does nothing outside idle.
               result.event_res = EV_NONE;
            end else if (item.key_code != KEY_A) begin
               if (phase_ff inside {PH_OPEN, PH_OLD}) begin
                  if (!(room && item.key_code == stored_ff[idx])) begin
                     match_in = 1'b0;
                  end
               end else if (room) begin
                  if (phase_ff == PH_NEW) begin
                     first_in[idx] = item.key_code;
                  end else begin
                     second_in[idx] = item.key_code;
                  end
               end
               if (count_ff != COUNT_MAX) begin
                  count_in = count_ff + 5'd1;
               end
               result.event_res = EV_ECHO;
            end else begin
               match_in = 1'b1;
               count_in = 5'd0;
               case (phase_ff)
                  PH_OPEN: begin
                     phase_in         = PH_IDLE;
                     result.event_res = correct ? EV_UNLOCK : EV_WRONG;
                     result.unlock    = correct;
                  end
                  PH_OLD: begin
                     phase_in         = correct ? PH_NEW : PH_IDLE;
                     result.event_res = correct ? EV_NEW_OK : EV_WRONG;
                  end
                  PH_NEW: begin
                     phase_in         = PH_CONFIRM;
                     result.event_res = EV_STARTED;
                  end
                  default: begin
                     phase_in = PH_IDLE;
                     if (first_ff == second_ff) begin
                        stored_in        = second_ff;
                        result.event_res = EV_CHANGED;
                        result.save_code = 1'b1;
                     end else begin
                        result.event_res = EV_MISMATCH;
                     end
                  end
               endcase
            end
         end
         default: begin
            // Idle; any code outside the phase set is taken as idle too.
            phase_in = PH_IDLE;
            match_in = 1'b1;
            count_in = 5'd0;
            if (item.mode) begin
               result.event_res = EV_UNLOCK;
               result.unlock    = 1'b1;
            end else if (item.key_code == KEY_STAR) begin
               phase_in         = PH_OPEN;
               result.event_res = EV_STARTED;
            end else if (item.key_code == KEY_HASH) begin
               phase_in         = PH_OLD;
               result.event_res = EV_STARTED;
            end
         end
      endcase

      word = 16'd0;
      for (int k = 0; k < SHOWN; k++) begin
         word[15 - 4 * k -: 4] = stored_in[k];
      end
      result.code_word     = word;
      result.phase         = phase_in;
      result.entered_count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         match_ff  <= 1'b1;
         count_ff  <= 5'd0;
         // Keys past the fourth start out as zero.
         for (int k = 0; k < CODE_LEN; k++) begin
            stored_ff[k] <= (k < SHOWN) ? RESET_CODE[2'(k)] : 4'd0;
         end
         first_ff  <= '0;
         second_ff <= '0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         match_ff  <= match_in;
         count_ff  <= count_in;
         stored_ff <= stored_in;
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

   // Every entry starts from a clean count and match flag.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> count_ff == 5'd0 && match_ff)
      else $error("idle with a stale entry count or match flag");

   // A save stores exactly the confirmed buffer.
   assert property (@(posedge clock) disable iff (reset)
      fire && result.save_code |=> stored_ff == $past(second_ff))
      else $error("saved code differs from the confirmed entry");

   // State moves only when a beat is processed.
   assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(phase_ff) && $stable(count_ff) && $stable(stored_ff))
      else $error("lock state changed without a beat");

endmodule

FILE: rtl/kcl_out_stage.sv
// Result register of the keypad code lock controller.
module kcl_out_stage
   import kcl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        item_valid,
   input  result_type  result,
   output logic        load,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_res,
   output logic        rsp_unlock,
   output logic        rsp_save_code,
   output logic [15:0] rsp_code_word,
   output logic [2:0]  rsp_phase,
   output logic [4:0]  rsp_entered_count
);

   logic       valid_ff;
   result_type result_ff;

   // The register takes a new beat whenever its current one leaves or it is empty.
   assign load = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= item_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && item_valid) begin
         result_ff <= result;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_event_res     = result_ff.event_res;
   assign rsp_unlock        = result_ff.unlock;
   assign rsp_save_code     = result_ff.save_code;
   assign rsp_code_word     = result_ff.code_word;
   assign rsp_phase         = result_ff.phase;
   assign rsp_entered_count = result_ff.entered_count;

endmodule

FILE: rtl/keypad_code_lock_controller.sv
// Top level of the keypad code lock controller.
//
//  Channel  Direction  Handshake             Payload
//  req      in         req_valid/req_stall   req_mode, req_key_code
//  rsp      out        rsp_valid/rsp_stall   rsp_event_res, rsp_unlock, rsp_save_code,
//                                            rsp_code_word, rsp_phase, rsp_entered_count
//
// Each accepted beat gives exactly one result beat, by way of the input register and
// then the result register, and a new beat can be accepted in every cycle while rsp
// does not stall; the rate is set by the single pass of next-state logic between them.
// Reset is synchronous and active high; it restores the stored code 6,6,0,1, idle
// phase and cleared new-code buffers at once.
// A stall on rsp holds the result register, which in turn holds the input register
// and raises req_stall only while both registers are occupied.
module keypad_code_lock_controller
   import kcl_pkg::*;
#(
   // Number of keys in the lock code, from one to eight.
   parameter int CODE_LEN = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [3:0]  req_key_code,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_res,
   output logic        rsp_unlock,
   output logic        rsp_save_code,
   output logic [15:0] rsp_code_word,
   output logic [2:0]  rsp_phase,
   output logic [4:0]  rsp_entered_count
);

   item_type   item;
   result_type result;
   logic       item_valid;
   logic       load;
   logic       fire;

   // A beat is processed when it sits in the input register and the result
   // register can take its result in the same edge.
   assign fire = item_valid && load;

   kcl_in_stage u_in_stage (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_mode     (req_mode),
      .req_key_code (req_key_code),
      .take         (load),
      .item_valid   (item_valid),
      .item         (item)
   );

   // The engine holds the phase, the stored code and both new-code buffers,
   // and updates them once per processed beat.
   kcl_engine #(
      .CODE_LEN (CODE_LEN)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item),
      .result (result)
   );

   kcl_out_stage u_out_stage (
      .clock             (clock),
      .reset             (reset),
      .item_valid        (item_valid),
      .result            (result),
      .load              (load),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_res     (rsp_event_res),
      .rsp_unlock        (rsp_unlock),
      .rsp_save_code     (rsp_save_code),
      .rsp_code_word     (rsp_code_word),
      .rsp_phase         (rsp_phase),
      .rsp_entered_count (rsp_entered_count)
   );

endmodule
